[sv/rvex_pkg.sv]
// rvex_pkg: opcode and function codes, field widths and the register
// file reset function of the RV32I subset execute step.
// No dependencies; the top level takes everything it needs from here by scoped names.
`default_nettype none

package rvex_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned RIDX = 5;

    // major opcodes
    localparam logic [6:0] OPC_OP     = 7'd51;
    localparam logic [6:0] OPC_OP_IMM = 7'd19;
    localparam logic [6:0] OPC_LOAD   = 7'd3;
    localparam logic [6:0] OPC_STORE  = 7'd35;
    localparam logic [6:0] OPC_BRANCH = 7'd99;

    // funct3 codes, ALU group
    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_XOR = 3'd4;
    localparam logic [2:0] F3_SR  = 3'd5;
    localparam logic [2:0] F3_OR  = 3'd6;
    localparam logic [2:0] F3_AND = 3'd7;

    // funct3 codes, branch group and word access
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_WORD = 3'd2;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_ALT  = 7'd32;

    // program counter after reset
    localparam logic [XLEN-1:0] PC_RESET = 32'd1000;

    // result item carried by the output register
    typedef struct packed {
        logic [XLEN-1:0] current_pc;
        logic [XLEN-1:0] next_pc;
        logic            branch_taken;
        logic            write_enable;
        logic [RIDX-1:0] write_register;
        logic [XLEN-1:0] write_value;
        logic            illegal;
    } t_result;

    // value that a register holds until it is first written: x1..x5 hold their index
    function automatic logic [XLEN-1:0] reg_reset_value(input logic [RIDX-1:0] idx);
        logic [XLEN-1:0] v;
        v = '0;
        if (idx >= 5'd1 && idx <= 5'd5) begin
            v = {{(XLEN-RIDX){1'b0}}, idx};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/rvex_if.sv]
// rvex channel interfaces: instruction input, result output and the
// start address write channel. Depends on rvex_pkg for field widths.
`default_nettype none

interface rvex_in_if;
    logic                      valid;
    logic                      ready;
    logic [rvex_pkg::XLEN-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface rvex_out_if;
    logic                      valid;
    logic                      ready;
    logic [rvex_pkg::XLEN-1:0] current_pc;
    logic [rvex_pkg::XLEN-1:0] next_pc;
    logic                      branch_taken;
    logic                      write_enable;
    logic [rvex_pkg::RIDX-1:0] write_register;
    logic signed [rvex_pkg::XLEN-1:0] write_value;
    logic                      illegal;

    modport source (output valid, output current_pc, output next_pc, output branch_taken,
                    output write_enable, output write_register, output write_value,
                    output illegal, input ready);
    modport sink   (input valid, input current_pc, input next_pc, input branch_taken,
                    input write_enable, input write_register, input write_value,
                    input illegal, output ready);
endinterface

interface rvex_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [rvex_pkg::XLEN-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/rv32i_subset_execute_step.sv]
// rv32i_subset_execute_step: top level, executes one RV32I subset instruction per transfer.
// Depends on rvex_pkg and the channel interfaces in rvex_if.sv.
//
// Usage:
//   i_in  : instruction words, one per transfer, fetched at the current program counter.
//   o_out : one result per instruction: executed pc, next pc, branch taken, register
//           write (enable, index, value) and an illegal flag.
//   i_cfg : writes start_address and loads the program counter with it at once.
//           Always ready; write only while no instruction is in flight.
// Path: an instruction taken on i_in goes through two registers, the execute register
//   and then the output register, before its result shows on o_out.
// Throughput: one instruction per cycle while o_out is not held. The register file is
//   read into the execute register on input transfer and written when the result moves
//   to the output register; a write at that same edge is forwarded to the new instruction.
// Stall: when o_out is held, the output register keeps its result and the execute
//   register still takes one more instruction; after that i_in.ready drops.
// Reset: synchronous, active low. PC returns to 1000, x1..x5 read as their index
//   and all other registers as zero (per-entry valid bits, cleared at once), and
//   both pipeline registers empty.
`default_nettype none

module rv32i_subset_execute_step #(
    parameter int unsigned REG_COUNT = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rvex_in_if.sink       i_in,
    rvex_cfg_if.sink      i_cfg,
    rvex_out_if.source    o_out
);

    localparam int unsigned XLEN = rvex_pkg::XLEN;
    localparam int unsigned RIDX = rvex_pkg::RIDX;
    localparam int unsigned IW   = $clog2(REG_COUNT);

    // register file storage and per-entry valid bits
    logic [XLEN-1:0]      r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;

    // execute register
    logic            r_ex_valid;
    logic [XLEN-1:0] r_ins;
    logic [XLEN-1:0] r_mem_a, r_mem_b;
    logic            r_vld_a, r_vld_b;
    logic            r_byp_a, r_byp_b;
    logic [XLEN-1:0] r_byp_val;
    logic [XLEN-1:0] r_pc;

    // output register
    logic                r_out_valid;
    rvex_pkg::t_result   r_out;

    // handshake
    logic in_xfer, ex_advance;
    assign ex_advance = r_ex_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_ex_valid || ex_advance;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // incoming source indexes
    logic [RIDX-1:0] in_rs1, in_rs2;
    assign in_rs1 = i_in.instruction[19:15];
    assign in_rs2 = i_in.instruction[24:20];

    // decode fields of the instruction in execute
    logic [6:0]      opcode, f7;
    logic [2:0]      f3;
    logic [RIDX-1:0] rd, rs1, rs2;
    assign opcode = r_ins[6:0];
    assign rd     = r_ins[11:7];
    assign f3     = r_ins[14:12];
    assign rs1    = r_ins[19:15];
    assign rs2    = r_ins[24:20];
    assign f7     = r_ins[31:25];

    // operand select: out of range, forwarded, written, or reset value
    logic [XLEN-1:0] op_a, op_b;
    always_comb begin
        if (32'(rs1) >= 32'(REG_COUNT)) begin
            op_a = '0;
        end else if (r_byp_a) begin
            op_a = r_byp_val;
        end else if (r_vld_a) begin
            op_a = r_mem_a;
        end else begin
            op_a = rvex_pkg::reg_reset_value(rs1);
        end
        if (32'(rs2) >= 32'(REG_COUNT)) begin
            op_b = '0;
        end else if (r_byp_b) begin
            op_b = r_byp_val;
        end else if (r_vld_b) begin
            op_b = r_mem_b;
        end else begin
            op_b = rvex_pkg::reg_reset_value(rs2);
        end
    end

    // immediates
    logic [XLEN-1:0] imm_i, imm_b;
    logic [4:0]      sh_i;
    assign imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
    assign sh_i  = r_ins[24:20];
    assign imm_b = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};

    // execute
    logic            ex_ill, ex_taken, ex_wr_raw, ex_wr;
    logic [XLEN-1:0] ex_val, ex_npc;
    always_comb begin
        ex_ill    = 1'b0;
        ex_taken  = 1'b0;
        ex_wr_raw = 1'b0;
        ex_val    = '0;
        unique case (opcode)
            rvex_pkg::OPC_OP: begin
                ex_wr_raw = 1'b1;
                unique case (f3)
                    rvex_pkg::F3_ADD: begin
                        if (f7 == rvex_pkg::F7_BASE) ex_val = op_a + op_b;
                        else if (f7 == rvex_pkg::F7_ALT) ex_val = op_a - op_b;
                        else ex_ill = 1'b1;
                    end
                    rvex_pkg::F3_SLL: begin
                        if (f7 == rvex_pkg::F7_BASE) ex_val = op_a << op_b[4:0];
                        else ex_ill = 1'b1;
                    end
                    rvex_pkg::F3_XOR: begin
                        if (f7 == rvex_pkg::F7_BASE) ex_val = op_a ^ op_b;
                        else ex_ill = 1'b1;
                    end
                    rvex_pkg::F3_SR: begin
                        if (f7 == rvex_pkg::F7_BASE) ex_val = op_a >> op_b[4:0];
                        else if (f7 == rvex_pkg::F7_ALT)
                            ex_val = $unsigned($signed(op_a) >>> op_b[4:0]);
                        else ex_ill = 1'b1;
                    end
                    rvex_pkg::F3_OR: begin
                        if (f7 == rvex_pkg::F7_BASE) ex_val = op_a | op_b;
                        else ex_ill = 1'b1;
                    end
                    rvex_pkg::F3_AND: begin
                        if (f7 == rvex_pkg::F7_BASE) ex_val = op_a & op_b;
                        else ex_ill = 1'b1;
                    end
                    default: ex_ill = 1'b1;
                endcase
            end
            rvex_pkg::OPC_OP_IMM: begin
                ex_wr_raw = 1'b1;
                unique case (f3)
                    rvex_pkg::F3_ADD: ex_val = op_a + imm_i;
                    rvex_pkg::F3_XOR: ex_val = op_a ^ imm_i;
                    rvex_pkg::F3_OR:  ex_val = op_a | imm_i;
                    rvex_pkg::F3_AND: ex_val = op_a & imm_i;
                    rvex_pkg::F3_SLL: begin
                        if (f7 == rvex_pkg::F7_BASE) ex_val = op_a << sh_i;
                        else ex_ill = 1'b1;
                    end
                    rvex_pkg::F3_SR: begin
                        if (f7 == rvex_pkg::F7_BASE) ex_val = op_a >> sh_i;
                        else if (f7 == rvex_pkg::F7_ALT)
                            ex_val = $unsigned($signed(op_a) >>> sh_i);
                        else ex_ill = 1'b1;
                    end
                    default: ex_ill = 1'b1;
                endcase
            end
            rvex_pkg::OPC_LOAD: begin
                // no data memory: a word load writes zero
                if (f3 == rvex_pkg::F3_WORD) ex_wr_raw = 1'b1;
                else ex_ill = 1'b1;
            end
            rvex_pkg::OPC_STORE: begin
                if (f3 != rvex_pkg::F3_WORD) ex_ill = 1'b1;
            end
            rvex_pkg::OPC_BRANCH: begin
                // offsets that are not a multiple of four are rejected
                if (r_ins[8]) begin
                    ex_ill = 1'b1;
                end else begin
                    unique case (f3)
                        rvex_pkg::F3_BEQ: ex_taken = (op_a == op_b);
                        rvex_pkg::F3_BNE: ex_taken = (op_a != op_b);
                        rvex_pkg::F3_BLT: ex_taken = ($signed(op_a) < $signed(op_b));
                        rvex_pkg::F3_BGE: ex_taken = ($signed(op_a) >= $signed(op_b));
                        default:          ex_ill   = 1'b1;
                    endcase
                end
            end
            default: ex_ill = 1'b1;
        endcase
        if (ex_ill) ex_taken = 1'b0;
    end

    assign ex_wr  = ex_wr_raw && !ex_ill && (rd != '0) && (32'(rd) < 32'(REG_COUNT));
    assign ex_npc = ex_taken ? (r_pc + imm_b) : (r_pc + 32'd4);

    logic rf_write;
    assign rf_write = ex_advance && ex_wr;

    // register file: write on advance, registered reads on input transfer
    always_ff @(posedge i_clk) begin
        if (rf_write) begin
            r_rf[rd[IW-1:0]] <= ex_val;
        end
        if (in_xfer) begin
            r_mem_a <= r_rf[in_rs1[IW-1:0]];
            r_mem_b <= r_rf[in_rs2[IW-1:0]];
        end
    end

    // valid bits of the register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (rf_write) begin
            r_vld[rd[IW-1:0]] <= 1'b1;
        end
    end

    // execute register payload, with forwarding of the write at this edge
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ins     <= i_in.instruction;
            r_vld_a   <= r_vld[in_rs1[IW-1:0]] || (rf_write && rd[IW-1:0] == in_rs1[IW-1:0]);
            r_vld_b   <= r_vld[in_rs2[IW-1:0]] || (rf_write && rd[IW-1:0] == in_rs2[IW-1:0]);
            r_byp_a   <= rf_write && (rd == in_rs1);
            r_byp_b   <= rf_write && (rd == in_rs2);
            r_byp_val <= ex_val;
        end
    end

    // execute valid and program counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
            r_pc       <= rvex_pkg::PC_RESET;
        end else begin
            if (in_xfer) r_ex_valid <= 1'b1;
            else if (ex_advance) r_ex_valid <= 1'b0;
            if (i_cfg.valid) r_pc <= i_cfg.data;
            else if (ex_advance) r_pc <= ex_npc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ex_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_advance) begin
            r_out.current_pc     <= r_pc;
            r_out.next_pc        <= ex_npc;
            r_out.branch_taken   <= ex_taken;
            r_out.write_enable   <= ex_wr;
            r_out.write_register <= ex_wr ? rd : '0;
            r_out.write_value    <= ex_wr ? ex_val : '0;
            r_out.illegal        <= ex_ill;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.current_pc     = r_out.current_pc;
    assign o_out.next_pc        = r_out.next_pc;
    assign o_out.branch_taken   = r_out.branch_taken;
    assign o_out.write_enable   = r_out.write_enable;
    assign o_out.write_register = r_out.write_register;
    assign o_out.write_value    = $signed(r_out.write_value);
    assign o_out.illegal        = r_out.illegal;

    // checks
    a_ill_falls_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_advance && ex_ill) |=> (o_out.valid && o_out.next_pc == o_out.current_pc + 32'd4))
        else $error("illegal instruction did not fall through");

    a_pc_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_advance |=> (o_out.current_pc == $past(r_pc) && r_pc == $past(ex_npc)))
        else $error("program counter and result disagree");

    a_write_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.write_enable) |-> (o_out.write_register != '0 && !o_out.illegal
                                                 && !o_out.branch_taken))
        else $error("register write reported with zero index or illegal instruction");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while execute register is stalled");

endmodule

`default_nettype wire

[tb/sv/rv32i_subset_execute_step_test.sv]
// Self-checking testbench for rv32i_subset_execute_step: a directed instruction sequence,
// then random programs at several start addresses, checked against an in-bench executor.
// Depends on rvex_pkg and the channel interfaces in rvex_if.sv.
`default_nettype none

module rv32i_subset_execute_step_test;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned HOLD_AT     = 150;

    // encodings the block must reject
    localparam logic [2:0] F3_RSVD2 = 3'd2;
    localparam logic [2:0] F3_RSVD3 = 3'd3;
    localparam logic [6:0] F7_RSVD  = 7'd1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rvex_in_if  in_ch ();
    rvex_out_if out_ch ();
    rvex_cfg_if cfg_ch ();

    rv32i_subset_execute_step uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // architectural state of the executor
    logic [rvex_pkg::XLEN-1:0] gpr [0:31];
    logic [rvex_pkg::XLEN-1:0] model_pc;

    logic [rvex_pkg::XLEN-1:0] pending_insns [$];
    rvex_pkg::t_result         expected_results [$];

    int unsigned idle_stage = 0;
    int unsigned errors = 0;
    int unsigned results_checked = 0;
    int unsigned taken_count = 0;
    int unsigned illegal_count = 0;
    int unsigned write_count = 0;
    int unsigned start_writes = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_hold_left = 0;
    bit          sink_hold_done = 1'b0;

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // instruction encoders
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, rvex_pkg::OPC_OP};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, rvex_pkg::F3_WORD, imm[4:0], rvex_pkg::OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rvex_pkg::OPC_BRANCH};
    endfunction

    // half the picks are drawn from x0..x7 only, so that results feed later instructions
    function automatic logic [4:0] pick_reg();
        return $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
    endfunction

    function automatic logic [2:0] pick_alu_f3();
        case ($urandom_range(5))
            0: return rvex_pkg::F3_ADD;
            1: return rvex_pkg::F3_SLL;
            2: return rvex_pkg::F3_XOR;
            3: return rvex_pkg::F3_SR;
            4: return rvex_pkg::F3_OR;
            default: return rvex_pkg::F3_AND;
        endcase
    endfunction

    // mostly well-formed instructions, some near misses and raw noise
    function automatic logic [31:0] rand_insn();
        logic [31:0] w;
        logic [11:0] imm;
        logic [12:0] boff;
        logic [2:0]  f3;
        logic [4:0]  rs1;
        int          kind;
        w    = $urandom();
        imm  = 12'($urandom());
        boff = 13'($urandom());
        kind = $urandom_range(99);
        if (kind < 30) begin
            f3 = pick_alu_f3();
            w = enc_r(((f3 == rvex_pkg::F3_ADD || f3 == rvex_pkg::F3_SR) && $urandom_range(1))
                          ? rvex_pkg::F7_ALT : rvex_pkg::F7_BASE,
                      pick_reg(), pick_reg(), f3, pick_reg());
        end else if (kind < 55) begin
            f3 = pick_alu_f3();
            if (f3 == rvex_pkg::F3_SLL) imm[11:5] = rvex_pkg::F7_BASE;
            if (f3 == rvex_pkg::F3_SR)
                imm[11:5] = $urandom_range(1) ? rvex_pkg::F7_ALT : rvex_pkg::F7_BASE;
            w = enc_i(imm, pick_reg(), f3, pick_reg(), rvex_pkg::OPC_OP_IMM);
        end else if (kind < 62) begin
            w = enc_i(imm, pick_reg(), rvex_pkg::F3_WORD, pick_reg(), rvex_pkg::OPC_LOAD);
        end else if (kind < 67) begin
            w = enc_s(imm, pick_reg(), pick_reg());
        end else if (kind < 85) begin
            case ($urandom_range(3))
                0: f3 = rvex_pkg::F3_BEQ;
                1: f3 = rvex_pkg::F3_BNE;
                2: f3 = rvex_pkg::F3_BLT;
                default: f3 = rvex_pkg::F3_BGE;
            endcase
            rs1 = pick_reg();
            boff[1:0] = 2'b00;
            w = enc_b(boff, ($urandom_range(3) == 0) ? rs1 : pick_reg(), rs1, f3);
        end else if (kind < 93) begin
            // a known opcode with random remaining bits
            case ($urandom_range(4))
                0: w[6:0] = rvex_pkg::OPC_OP;
                1: w[6:0] = rvex_pkg::OPC_OP_IMM;
                2: w[6:0] = rvex_pkg::OPC_LOAD;
                3: w[6:0] = rvex_pkg::OPC_STORE;
                default: w[6:0] = rvex_pkg::OPC_BRANCH;
            endcase
        end
        return w;
    endfunction

    // ---------------------------------------------------------------
    // executor: runs one instruction on the model state, returns its result
    function automatic rvex_pkg::t_result exec_insn(logic [31:0] ins);
        rvex_pkg::t_result r;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, imm, npc, val;
        logic        bad, taken, wr;
        rd  = ins[11:7];
        f3  = ins[14:12];
        rs1 = ins[19:15];
        rs2 = ins[24:20];
        f7  = ins[31:25];
        a   = (rs1 == 5'd0) ? '0 : gpr[rs1];
        b   = (rs2 == 5'd0) ? '0 : gpr[rs2];
        npc = model_pc + 32'd4;
        val = '0;
        bad = 1'b0;
        taken = 1'b0;
        wr  = 1'b0;
        case (ins[6:0])
            rvex_pkg::OPC_OP: begin
                wr = 1'b1;
                case (f3)
                    rvex_pkg::F3_ADD: begin
                        if (f7 == rvex_pkg::F7_BASE) val = a + b;
                        else if (f7 == rvex_pkg::F7_ALT) val = a - b;
                        else bad = 1'b1;
                    end
                    rvex_pkg::F3_SLL:
                        if (f7 == rvex_pkg::F7_BASE) val = a << b[4:0]; else bad = 1'b1;
                    rvex_pkg::F3_XOR:
                        if (f7 == rvex_pkg::F7_BASE) val = a ^ b; else bad = 1'b1;
                    rvex_pkg::F3_SR: begin
                        if (f7 == rvex_pkg::F7_BASE) val = a >> b[4:0];
                        else if (f7 == rvex_pkg::F7_ALT) val = $signed(a) >>> b[4:0];
                        else bad = 1'b1;
                    end
                    rvex_pkg::F3_OR:
                        if (f7 == rvex_pkg::F7_BASE) val = a | b; else bad = 1'b1;
                    rvex_pkg::F3_AND:
                        if (f7 == rvex_pkg::F7_BASE) val = a & b; else bad = 1'b1;
                    default: bad = 1'b1;
                endcase
            end
            rvex_pkg::OPC_OP_IMM: begin
                imm = {{20{ins[31]}}, ins[31:20]};
                wr = 1'b1;
                case (f3)
                    rvex_pkg::F3_ADD: val = a + imm;
                    rvex_pkg::F3_XOR: val = a ^ imm;
                    rvex_pkg::F3_OR:  val = a | imm;
                    rvex_pkg::F3_AND: val = a & imm;
                    rvex_pkg::F3_SLL:
                        if (f7 == rvex_pkg::F7_BASE) val = a << rs2; else bad = 1'b1;
                    rvex_pkg::F3_SR: begin
                        if (f7 == rvex_pkg::F7_BASE) val = a >> rs2;
                        else if (f7 == rvex_pkg::F7_ALT) val = $signed(a) >>> rs2;
                        else bad = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
            end
            // no data memory: loads return zero
            rvex_pkg::OPC_LOAD: if (f3 == rvex_pkg::F3_WORD) wr = 1'b1; else bad = 1'b1;
            rvex_pkg::OPC_STORE: if (f3 != rvex_pkg::F3_WORD) bad = 1'b1;
            rvex_pkg::OPC_BRANCH: begin
                imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                if (imm[1]) begin
                    bad = 1'b1;
                end else begin
                    case (f3)
                        rvex_pkg::F3_BEQ: taken = (a == b);
                        rvex_pkg::F3_BNE: taken = (a != b);
                        rvex_pkg::F3_BLT: taken = ($signed(a) < $signed(b));
                        rvex_pkg::F3_BGE: taken = ($signed(a) >= $signed(b));
                        default: bad = 1'b1;
                    endcase
                end
                if (bad) taken = 1'b0;
                if (taken) npc = model_pc + imm;
            end
            default: bad = 1'b1;
        endcase
        if (bad || rd == 5'd0) wr = 1'b0;
        if (wr) gpr[rd] = val;
        else val = '0;
        r.current_pc     = model_pc;
        r.next_pc        = npc;
        r.branch_taken   = taken;
        r.write_enable   = wr;
        r.write_register = wr ? rd : 5'd0;
        r.write_value    = val;
        r.illegal        = bad;
        model_pc = npc;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------
    // instruction driver: predicts each result at its input transfer
    always @(posedge i_clk) begin : drive_insns
        int unsigned src_idle_pct;
        src_idle_pct = (idle_stage == 0) ? 18 : (idle_stage == 1) ? 87 : 0;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(exec_insn(in_ch.instruction));
            end
            // never drop valid while a transfer is still waiting
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_insns.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.instruction <= pending_insns.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // one long receiver hold-off, counted in cycles, while the sender keeps offering
    always @(posedge i_clk) begin : hold_sink
        if (i_rst_n) begin
            if (results_checked == HOLD_AT && !sink_hold_done) begin
                sink_hold_left <= HOLD_CYCLES;
                sink_hold_done <= 1'b1;
            end else if (sink_hold_left != 0) begin
                sink_hold_left <= sink_hold_left - 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor with random and long back-pressure
    always @(posedge i_clk) begin : watch_results
        rvex_pkg::t_result want;
        int unsigned       sink_idle_pct;
        sink_idle_pct = (idle_stage == 0) ? 87 : (idle_stage == 1) ? 18 : 0;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, pc %h", $time, out_ch.current_pc);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("current_pc", want.current_pc, out_ch.current_pc);
                    check_field("next_pc", want.next_pc, out_ch.next_pc);
                    check_field("branch_taken", 32'(want.branch_taken), 32'(out_ch.branch_taken));
                    check_field("write_enable", 32'(want.write_enable), 32'(out_ch.write_enable));
                    check_field("write_register", 32'(want.write_register),
                                32'(out_ch.write_register));
                    check_field("write_value", want.write_value, out_ch.write_value);
                    check_field("illegal", 32'(want.illegal), 32'(out_ch.illegal));
                    taken_count += want.branch_taken;
                    illegal_count += want.illegal;
                    write_count += want.write_enable;
                end
                results_checked++;
            end
            if (sink_hold_left != 0) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequencing: phases of instructions, start address writes between them
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_insns.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_start(logic [31:0] addr);
        // let the pipeline settle before touching the PC
        repeat (3) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= addr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        model_pc = addr;
        start_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic queue_random(int unsigned n);
        repeat (n) pending_insns.push_back(rand_insn());
    endtask

    initial begin : run_phases
        in_ch.valid = 1'b0;
        in_ch.instruction = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        for (int i = 0; i < 32; i++) gpr[i] = (i >= 1 && i <= 5) ? 32'(i) : '0;
        model_pc = 32'd1000;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every operation and the rejection cases, from the reset PC
        pending_insns.push_back(enc_r(rvex_pkg::F7_BASE, 5'd2, 5'd1, rvex_pkg::F3_ADD, 5'd6));
        pending_insns.push_back(enc_r(rvex_pkg::F7_ALT, 5'd5, 5'd1, rvex_pkg::F3_ADD, 5'd7));
        pending_insns.push_back(enc_i(12'hFFF, 5'd0, rvex_pkg::F3_ADD, 5'd9,
                                      rvex_pkg::OPC_OP_IMM));
        pending_insns.push_back(enc_i(12'h7FF, 5'd0, rvex_pkg::F3_ADD, 5'd13,
                                      rvex_pkg::OPC_OP_IMM));
        // shift amount from x9 = -1: only the low 5 bits count
        pending_insns.push_back(enc_r(rvex_pkg::F7_BASE, 5'd9, 5'd5, rvex_pkg::F3_SLL, 5'd10));
        pending_insns.push_back(enc_r(rvex_pkg::F7_BASE, 5'd4, 5'd9, rvex_pkg::F3_SR, 5'd11));
        pending_insns.push_back(enc_r(rvex_pkg::F7_ALT, 5'd4, 5'd9, rvex_pkg::F3_SR, 5'd12));
        pending_insns.push_back(enc_r(rvex_pkg::F7_BASE, 5'd7, 5'd13, rvex_pkg::F3_XOR, 5'd15));
        pending_insns.push_back(enc_r(rvex_pkg::F7_BASE, 5'd7, 5'd3, rvex_pkg::F3_OR, 5'd16));
        pending_insns.push_back(enc_r(rvex_pkg::F7_BASE, 5'd7, 5'd13, rvex_pkg::F3_AND, 5'd17));
        pending_insns.push_back(enc_i(12'h0AA, 5'd7, rvex_pkg::F3_XOR, 5'd18,
                                      rvex_pkg::OPC_OP_IMM));
        pending_insns.push_back(enc_i(12'h800, 5'd3, rvex_pkg::F3_OR, 5'd19,
                                      rvex_pkg::OPC_OP_IMM));
        pending_insns.push_back(enc_i(12'hF0F, 5'd7, rvex_pkg::F3_AND, 5'd20,
                                      rvex_pkg::OPC_OP_IMM));
        pending_insns.push_back(enc_i({rvex_pkg::F7_BASE, 5'd31}, 5'd5, rvex_pkg::F3_SLL, 5'd21,
                                      rvex_pkg::OPC_OP_IMM));
        pending_insns.push_back(enc_i({rvex_pkg::F7_BASE, 5'd1}, 5'd7, rvex_pkg::F3_SR, 5'd22,
                                      rvex_pkg::OPC_OP_IMM));
        pending_insns.push_back(enc_i({rvex_pkg::F7_ALT, 5'd31}, 5'd7, rvex_pkg::F3_SR, 5'd23,
                                      rvex_pkg::OPC_OP_IMM));
        pending_insns.push_back(enc_i(12'h010, 5'd1, rvex_pkg::F3_WORD, 5'd24,
                                      rvex_pkg::OPC_LOAD));
        pending_insns.push_back(enc_s(12'hFFC, 5'd2, 5'd1));
        // write to x0 is dropped
        pending_insns.push_back(enc_r(rvex_pkg::F7_BASE, 5'd2, 5'd1, rvex_pkg::F3_ADD, 5'd0));
        pending_insns.push_back(enc_b(13'd8, 5'd1, 5'd1, rvex_pkg::F3_BEQ));
        pending_insns.push_back(enc_b(13'd8, 5'd1, 5'd1, rvex_pkg::F3_BNE));
        // extreme offsets, signed compare against x7 = -4
        pending_insns.push_back(enc_b(13'h1000, 5'd1, 5'd7, rvex_pkg::F3_BLT));
        pending_insns.push_back(enc_b(13'h0FFC, 5'd7, 5'd1, rvex_pkg::F3_BGE));
        // misaligned branch target, unknown opcode, bad function fields
        pending_insns.push_back(enc_b(13'd6, 5'd1, 5'd1, rvex_pkg::F3_BEQ));
        pending_insns.push_back(32'h0000_0000);
        pending_insns.push_back(enc_r(F7_RSVD, 5'd2, 5'd1, rvex_pkg::F3_XOR, 5'd25));
        pending_insns.push_back(enc_i({rvex_pkg::F7_ALT, 5'd3}, 5'd1, rvex_pkg::F3_SLL, 5'd26,
                                      rvex_pkg::OPC_OP_IMM));
        pending_insns.push_back(enc_i(12'h000, 5'd1, F3_RSVD3, 5'd27, rvex_pkg::OPC_LOAD));
        pending_insns.push_back(enc_b(13'd8, 5'd1, 5'd1, F3_RSVD2));
        wait_drained();

        write_start(32'h0000_0000);
        queue_random(300);
        wait_drained();

        // PC wraps through the top of the address space
        idle_stage = 1;
        write_start(32'hFFFF_FFF8);
        queue_random(300);
        wait_drained();

        idle_stage = 2;
        write_start(32'hFFFF_FFFF);
        queue_random(200);
        wait_drained();

        write_start($urandom());
        queue_random(80);
        wait_drained();

        repeat (8) @(posedge i_clk);
        $display("Checked %0d results over %0d start addresses: %0d register writes,",
                 results_checked, start_writes, write_count);
        $display("%0d branches taken, %0d illegal encodings.", taken_count, illegal_count);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
